### rtl/core/pwdt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pwdt_pkg
// Shared types and constants for the per-core watchdog timer bank.
// ----------------------------------------------------------------------------
package pwdt_pkg;

  localparam int unsigned NumCoresDefault   = 8;
  localparam int unsigned CountWidthDefault = 32;

  localparam int unsigned CmdWidth  = 3;
  localparam int unsigned SelWidth  = 3;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned IrqWidth  = 8;

  localparam int unsigned InTdataWidth  = 40;
  localparam int unsigned OutTdataWidth = 48;

  localparam logic [4:0] CtlKeepMask = 5'h1F;
  localparam int unsigned CtlStartBit = 0;
  localparam int unsigned CtlIrqBit   = 6;
  localparam int unsigned CtlResetBit = 7;

  typedef enum logic [CmdWidth-1:0] {
    CMD_TICK      = 3'd0,
    CMD_WR_START  = 3'd1,
    CMD_WR_CTL    = 3'd2,
    CMD_RD_CTL    = 3'd3,
    CMD_RD_COUNT  = 3'd4
  } pwdt_cmd_e;

  typedef enum logic [2:0] {
    MODE_ONESHOT  = 3'd0,
    MODE_SECOND   = 3'd1,
    MODE_PERIODIC = 3'd2
  } pwdt_mode_e;

  // request to one core, valid for the cycle the item is processed
  typedef struct packed {
    logic tick;
    logic wr_start;
    logic wr_ctl;
  } pwdt_req_t;

  typedef struct packed {
    logic expired;
    logic rst_req;
  } pwdt_status_t;

endpackage : pwdt_pkg
`default_nettype wire

### rtl/core/pwdt_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pwdt_core
// One watchdog timer: control, flags, down counter and start count.
// ----------------------------------------------------------------------------
module pwdt_core import pwdt_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = CountWidthDefault
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire pwdt_req_t              req_i,
  input  wire logic [DataWidth-1:0]   data_i,
  output pwdt_status_t                status_o,
  output logic [DataWidth-1:0]        ctl_rd_o,
  output logic [DataWidth-1:0]        cnt_rd_o
);

  logic [4:0]             ctl_q, ctl_d;
  logic                   irq_q, irq_d;
  logic                   rst_q, rst_d;
  logic                   run_q, run_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [COUNT_WIDTH-1:0] start_q, start_d;

  logic [63:0]            data_ext;
  logic [63:0]            cnt_ext;
  pwdt_mode_e             mode;
  logic                   expire;

  assign data_ext = {32'd0, data_i};
  assign cnt_ext  = 64'(cnt_q);
  assign mode     = pwdt_mode_e'(ctl_q[3:1]);
  assign expire   = req_i.tick && run_q && (cnt_q <= COUNT_WIDTH'(1));

  always_comb begin
    ctl_d   = ctl_q;
    irq_d   = irq_q;
    rst_d   = rst_q;
    run_d   = run_q;
    cnt_d   = cnt_q;
    start_d = start_q;
    status_o = '0;
    if (req_i.tick && run_q) begin
      if (!expire) begin
        cnt_d = cnt_q - COUNT_WIDTH'(1);
      end else begin
        irq_d = 1'b1;
        status_o.expired = 1'b1;
        case (mode)
          MODE_SECOND: begin
            if (irq_q) begin
              rst_d = 1'b1;
              status_o.rst_req = 1'b1;
            end
            cnt_d = start_q;
          end
          MODE_PERIODIC: begin
            cnt_d = start_q;
          end
          default: begin
            run_d = 1'b0;
            cnt_d = '0;
          end
        endcase
      end
    end
    if (req_i.wr_start) begin
      start_d = data_ext[COUNT_WIDTH-1:0];
    end
    if (req_i.wr_ctl) begin
      if (ctl_q[CtlStartBit] != data_i[CtlStartBit]) begin
        if (data_i[CtlStartBit]) begin
          cnt_d = start_q;
          run_d = 1'b1;
        end else begin
          run_d = 1'b0;
        end
      end
      ctl_d = data_i[4:0] & CtlKeepMask;
      irq_d = 1'b0;
      rst_d = 1'b0;
    end
  end

  always_comb begin
    ctl_rd_o = {24'd0, rst_q, irq_q, 1'b0, ctl_q};
    cnt_rd_o = run_q ? cnt_ext[DataWidth-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q   <= '0;
      irq_q   <= 1'b0;
      rst_q   <= 1'b0;
      run_q   <= 1'b0;
      cnt_q   <= '0;
      start_q <= '0;
    end else begin
      ctl_q   <= ctl_d;
      irq_q   <= irq_d;
      rst_q   <= rst_d;
      run_q   <= run_d;
      cnt_q   <= cnt_d;
      start_q <= start_d;
    end
  end

endmodule : pwdt_core
`default_nettype wire

### rtl/core/per_core_watchdog_timer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// per_core_watchdog_timer
// Bank of per-core watchdog timers driven by a request stream.
// Throughput: 1 request per cycle while m_axis_tready does not stall the
// output; all cores update in parallel when the request in the input
// register is processed, results held in an output register.
// Reset: asynchronous, all timers stopped, counts, start counts and flags 0.
// ----------------------------------------------------------------------------
module per_core_watchdog_timer import pwdt_pkg::*; #(
  parameter int unsigned NUM_CORES   = NumCoresDefault,
  parameter int unsigned COUNT_WIDTH = CountWidthDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  // [2:0] core_select, [34:3] write_data
  input  wire logic [InTdataWidth-1:0]  s_axis_tdata,
  // [2:0] cmd
  input  wire logic [CmdWidth-1:0]      s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  // [31:0] read_data, [39:32] irq_mask, [40] system_reset
  output logic [OutTdataWidth-1:0]      m_axis_tdata
);

  localparam int unsigned SelCmpW = 7;

  logic                    in_valid_q;
  logic [CmdWidth-1:0]     cmd_q;
  logic [SelWidth-1:0]     sel_q;
  logic [DataWidth-1:0]    data_q;
  logic                    fire;
  logic                    out_free;

  logic                    out_valid_q;
  logic [OutTdataWidth-1:0] out_data_q, out_data_d;

  pwdt_req_t               req    [NUM_CORES];
  pwdt_status_t            status [NUM_CORES];
  logic [DataWidth-1:0]    ctl_rd [NUM_CORES];
  logic [DataWidth-1:0]    cnt_rd [NUM_CORES];
  logic [NUM_CORES-1:0]    hit;
  logic [IrqWidth-1:0]     irq_vec;
  logic                    sys_rst;
  logic [DataWidth-1:0]    rd_data;
  pwdt_cmd_e               cmd;

  assign cmd           = pwdt_cmd_e'(cmd_q);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      cmd_q  <= s_axis_tuser;
      sel_q  <= s_axis_tdata[SelWidth-1:0];
      data_q <= s_axis_tdata[SelWidth +: DataWidth];
    end
  end

  for (genvar g = 0; g < NUM_CORES; g++) begin : g_core
    assign hit[g]          = ({4'd0, sel_q} == SelCmpW'(g));
    assign req[g].tick     = fire && (cmd == CMD_TICK);
    assign req[g].wr_start = fire && hit[g] && (cmd == CMD_WR_START);
    assign req[g].wr_ctl   = fire && hit[g] && (cmd == CMD_WR_CTL);

    pwdt_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .req_i    (req[g]),
      .data_i   (data_q),
      .status_o (status[g]),
      .ctl_rd_o (ctl_rd[g]),
      .cnt_rd_o (cnt_rd[g])
    );
  end

  for (genvar g = 0; g < IrqWidth; g++) begin : g_irq
    if (g < NUM_CORES) begin : g_on
      assign irq_vec[g] = status[g].expired;
    end else begin : g_off
      assign irq_vec[g] = 1'b0;
    end
  end

  always_comb begin
    sys_rst = 1'b0;
    rd_data = '0;
    for (int i = 0; i < NUM_CORES; i++) begin
      sys_rst = sys_rst | status[i].rst_req;
      if (hit[i]) begin
        case (cmd)
          CMD_RD_CTL:   rd_data = rd_data | ctl_rd[i];
          CMD_RD_COUNT: rd_data = rd_data | cnt_rd[i];
          default:      rd_data = rd_data;
        endcase
      end
    end
    out_data_d = {7'd0, sys_rst, irq_vec, rd_data};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_rst_needs_irq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[40] |-> (m_axis_tdata[39:32] != '0))
    else $error("system reset without expiry");

  a_read_not_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[31:0] != '0) |-> (m_axis_tdata[40:32] == '0))
    else $error("read data and tick results mixed");

  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> m_axis_tvalid)
    else $error("processed request produced no result");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("empty input stage not ready");

endmodule : per_core_watchdog_timer
`default_nettype wire

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stream-level check of the per-core watchdog timer bank. A short table of
// requests covers reset values, unknown commands, count extremes and each
// timer mode, then several hundred random requests follow, built around small
// start counts so that timers expire, reload and escalate often. Every result
// is compared against the table's expected value or an in-bench model of the
// timer bank, with random input gaps and output stalls, and one long output hold-off.
// ----------------------------------------------------------------------------
module tb import pwdt_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CMD_RSVD_5 = 3'd5;
  localparam logic [2:0] CMD_RSVD_6 = 3'd6;
  localparam logic [2:0] CMD_RSVD_7 = 3'd7;

  localparam int unsigned RANDOM_REQS  = 350;
  localparam int unsigned HOLD_AT      = 150;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned TAIL_CYCLES  = 8;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned MAX_PRINTS   = 30;
  localparam int unsigned DIR_ROWS     = 26;

  // matches m_axis_tdata from bit 0 up: read_data, irq_mask, system_reset
  typedef struct packed {
    logic        sysrst;
    logic [7:0]  irq;
    logic [31:0] rd;
  } wdt_result_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [2:0]  sel;
    logic [31:0] data;
    logic        typed;
    wdt_result_t want;
  } dir_row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [InTdataWidth-1:0]  s_axis_tdata;
  logic [CmdWidth-1:0]      s_axis_tuser;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  logic [OutTdataWidth-1:0] m_axis_tdata;

  // timer bank model state
  logic [4:0]  tmr_ctl     [NumCoresDefault];
  logic        tmr_irq     [NumCoresDefault];
  logic        tmr_rst     [NumCoresDefault];
  logic        tmr_running [NumCoresDefault];
  logic [31:0] tmr_count   [NumCoresDefault];
  logic [31:0] tmr_start   [NumCoresDefault];

  wdt_result_t pending_results[$];
  dir_row_t    dir_rows[DIR_ROWS];
  int unsigned n_errors   = 0;
  int unsigned n_accepted = 0;
  int unsigned idle_cycles = 0;
  bit          idle_on = 1'b1;
  bit          rx_held = 1'b0;

  per_core_watchdog_timer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic dir_row_t row(input logic [2:0] cmd, input logic [2:0] sel,
                                   input logic [31:0] data, input logic typed,
                                   input logic sysrst, input logic [7:0] irq,
                                   input logic [31:0] rd);
    dir_row_t r;
    r.cmd  = cmd;
    r.sel  = sel;
    r.data = data;
    r.typed = typed;
    r.want.sysrst = sysrst;
    r.want.irq = irq;
    r.want.rd = rd;
    return r;
  endfunction

  function automatic wdt_result_t step_timer_bank(input logic [2:0] cmd,
                                                  input logic [2:0] sel,
                                                  input logic [31:0] data);
    wdt_result_t res;
    logic [2:0]  mode;
    res = '0;
    case (cmd)
      CMD_TICK: begin
        for (int c = 0; c < NumCoresDefault; c++) begin
          if (tmr_running[c]) begin
            if (tmr_count[c] > 32'd1) begin
              tmr_count[c] = tmr_count[c] - 32'd1;
            end else begin
              mode = tmr_ctl[c][3:1];
              if (mode == MODE_SECOND) begin
                if (tmr_irq[c]) begin
                  tmr_rst[c] = 1'b1;
                  res.sysrst = 1'b1;
                end
                tmr_count[c] = tmr_start[c];
              end else if (mode == MODE_PERIODIC) begin
                tmr_count[c] = tmr_start[c];
              end else begin
                tmr_running[c] = 1'b0;
                tmr_count[c] = '0;
              end
              tmr_irq[c] = 1'b1;
              res.irq[c] = 1'b1;
            end
          end
        end
      end
      CMD_WR_START: tmr_start[sel] = data;
      CMD_WR_CTL: begin
        if (tmr_ctl[sel][CtlStartBit] != data[CtlStartBit]) begin
          if (data[CtlStartBit]) begin
            tmr_count[sel] = tmr_start[sel];
            tmr_running[sel] = 1'b1;
          end else begin
            tmr_running[sel] = 1'b0;
          end
        end
        tmr_ctl[sel] = data[4:0] & CtlKeepMask;
        tmr_irq[sel] = 1'b0;
        tmr_rst[sel] = 1'b0;
      end
      CMD_RD_CTL: begin
        res.rd = {24'h0, tmr_rst[sel], tmr_irq[sel], 1'b0, tmr_ctl[sel]};
      end
      CMD_RD_COUNT: begin
        if (tmr_running[sel]) res.rd = tmr_count[sel];
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    n_errors++;
    if (n_errors <= MAX_PRINTS)
      $display("%0t: %s mismatch, expected %h, got %h", $realtime, what, want, got);
  endtask

  // drive one request, wait for it to be taken, record what it should return
  task automatic issue_request(input logic [2:0] cmd, input logic [2:0] sel,
                               input logic [31:0] data, input logic typed,
                               input wdt_result_t want);
    wdt_result_t predicted;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InTdataWidth'({data, sel});
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = step_timer_bank(cmd, sel, data);
    pending_results.push_back(typed ? want : predicted);
    n_accepted++;
    if (idle_on && $urandom_range(0, 2) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (pick_gap()) @(posedge clk_i);
    end
  endtask

  initial begin
    int unsigned counted;
    int unsigned r;
    logic [2:0]  cmd;
    logic [2:0]  sel;
    logic [31:0] data;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    for (int c = 0; c < NumCoresDefault; c++) begin
      tmr_ctl[c] = '0;
      tmr_irq[c] = 1'b0;
      tmr_rst[c] = 1'b0;
      tmr_running[c] = 1'b0;
      tmr_count[c] = '0;
      tmr_start[c] = '0;
    end

    dir_rows[0]  = row(CMD_RD_CTL,   3'd0, 32'h0,         1, 0, 8'h00, 32'h0);
    dir_rows[1]  = row(CMD_RD_COUNT, 3'd7, 32'h0,         1, 0, 8'h00, 32'h0);
    dir_rows[2]  = row(CMD_TICK,     3'd0, 32'h0,         1, 0, 8'h00, 32'h0);
    dir_rows[3]  = row(CMD_RSVD_5,   3'd7, 32'hFFFF_FFFF, 1, 0, 8'h00, 32'h0);
    dir_rows[4]  = row(CMD_RSVD_6,   3'd0, 32'hA5A5_A5A5, 1, 0, 8'h00, 32'h0);
    dir_rows[5]  = row(CMD_RSVD_7,   3'd3, 32'h5A5A_5A5A, 1, 0, 8'h00, 32'h0);
    dir_rows[6]  = row(CMD_WR_START, 3'd0, 32'hFFFF_FFFF, 1, 0, 8'h00, 32'h0);
    dir_rows[7]  = row(CMD_WR_CTL,   3'd0, 32'h0000_0005, 1, 0, 8'h00, 32'h0);
    dir_rows[8]  = row(CMD_RD_COUNT, 3'd0, 32'h0,         1, 0, 8'h00, 32'hFFFF_FFFF);
    dir_rows[9]  = row(CMD_RD_CTL,   3'd0, 32'h0,         1, 0, 8'h00, 32'h05);
    // start count of zero expires on the first tick
    dir_rows[10] = row(CMD_WR_START, 3'd1, 32'h0,         1, 0, 8'h00, 32'h0);
    dir_rows[11] = row(CMD_WR_CTL,   3'd1, 32'h0000_0001, 1, 0, 8'h00, 32'h0);
    dir_rows[12] = row(CMD_TICK,     3'd5, 32'h0,         1, 0, 8'h02, 32'h0);
    dir_rows[13] = row(CMD_RD_CTL,   3'd1, 32'h0,         1, 0, 8'h00, 32'h41);
    dir_rows[14] = row(CMD_RD_COUNT, 3'd1, 32'h0,         1, 0, 8'h00, 32'h0);
    // second countdown: unacknowledged expiry escalates to reset
    dir_rows[15] = row(CMD_WR_START, 3'd2, 32'h1,         1, 0, 8'h00, 32'h0);
    dir_rows[16] = row(CMD_WR_CTL,   3'd2, 32'h0000_0003, 1, 0, 8'h00, 32'h0);
    dir_rows[17] = row(CMD_TICK,     3'd0, 32'h0,         1, 0, 8'h04, 32'h0);
    dir_rows[18] = row(CMD_TICK,     3'd0, 32'h0,         1, 1, 8'h04, 32'h0);
    dir_rows[19] = row(CMD_RD_CTL,   3'd2, 32'h0,         1, 0, 8'h00, 32'hC3);
    dir_rows[20] = row(CMD_WR_CTL,   3'd2, 32'h0000_0002, 0, 0, 8'h00, 32'h0);
    // upper control bits dropped, mode 7 behaves as one-shot
    dir_rows[21] = row(CMD_WR_START, 3'd3, 32'h2,         0, 0, 8'h00, 32'h0);
    dir_rows[22] = row(CMD_WR_CTL,   3'd3, 32'hFFFF_FFFF, 0, 0, 8'h00, 32'h0);
    dir_rows[23] = row(CMD_TICK,     3'd0, 32'h0,         0, 0, 8'h00, 32'h0);
    dir_rows[24] = row(CMD_TICK,     3'd0, 32'h0,         0, 0, 8'h00, 32'h0);
    dir_rows[25] = row(CMD_RD_CTL,   3'd3, 32'h0,         0, 0, 8'h00, 32'h0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++)
      issue_request(dir_rows[i].cmd, dir_rows[i].sel, dir_rows[i].data,
                    dir_rows[i].typed, dir_rows[i].want);

    counted = 0;
    while (counted < RANDOM_REQS) begin
      if (counted % 50 == 0) idle_on = ($urandom_range(0, 2) != 0);
      r = $urandom_range(0, 99);
      sel = 3'($urandom_range(0, 7));
      data = $urandom;
      if (r < 40) begin
        cmd = CMD_TICK;
      end else if (r < 52) begin
        cmd = CMD_WR_START;
        r = $urandom_range(0, 19);
        if (r < 14) data = $urandom_range(0, 6);
        else if (r < 16) data = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
      end else if (r < 70) begin
        cmd = CMD_WR_CTL;
        r = $urandom_range(0, 9);
        if (r < 4) data[3:1] = MODE_SECOND;
        else if (r < 7) data[3:1] = MODE_PERIODIC;
        else if (r < 8) data[3:1] = MODE_ONESHOT;
        else data[3:1] = 3'($urandom_range(3, 7));
        data[CtlStartBit] = ($urandom_range(0, 3) != 0);
      end else if (r < 82) begin
        cmd = CMD_RD_CTL;
      end else if (r < 94) begin
        cmd = CMD_RD_COUNT;
      end else begin
        cmd = 3'($urandom_range(CMD_RSVD_5, CMD_RSVD_7));
      end
      issue_request(cmd, sel, data, 1'b0, '0);
      if (cmd <= CMD_RD_COUNT) counted++;
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("per_core_watchdog_timer verification clean");
    end else begin
      $display("per_core_watchdog_timer verification failed");
    end
    $finish;
  end

  // result side back-pressure, with one long hold-off to fill the pipe
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!rx_held && n_accepted >= HOLD_AT) begin
        rx_held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        if (stall_left == 0 && idle_on && $urandom_range(0, 3) == 0)
          stall_left = pick_gap();
        if (stall_left > 0) begin
          stall_left--;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    wdt_result_t got;
    wdt_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = wdt_result_t'(m_axis_tdata[$bits(wdt_result_t)-1:0]);
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result read_data", 32'h0, got.rd);
      end else begin
        want = pending_results.pop_front();
        if (got.rd !== want.rd) report_mismatch("read_data", want.rd, got.rd);
        if (got.irq !== want.irq) report_mismatch("irq_mask", 32'(want.irq), 32'(got.irq));
        if (got.sysrst !== want.sysrst)
          report_mismatch("system_reset", 32'(want.sysrst), 32'(got.sysrst));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("per_core_watchdog_timer verification failed");
        $finish;
      end
    end
  end

endmodule
